// ===== rtl/qtg_pkg.sv =====
// Shared constants, types and the microprogram of the quintic trajectory generator.
`default_nettype none
package qtg_pkg;

    // time format fraction bits (Q8.24)
    localparam int TIME_FRAC  = 24;
    localparam int SH_WIDE    = 2 * TIME_FRAC + 1;
    localparam int S_W        = TIME_FRAC + 1;
    localparam logic [S_W-1:0] S_ONE = S_W'(1) << TIME_FRAC;

    // configuration register indexes
    localparam logic [2:0] REG_START_POS = 3'd0;
    localparam logic [2:0] REG_START_VEL = 3'd1;
    localparam logic [2:0] REG_START_ACC = 3'd2;
    localparam logic [2:0] REG_TARGET    = 3'd3;
    localparam logic [2:0] REG_DURATION  = 3'd4;
    localparam logic [2:0] REG_INV_DUR   = 3'd5;

    // status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_ZERO_STEP = 2'd1;
    localparam logic [1:0] STAT_ZERO_DUR  = 2'd2;
    localparam logic [1:0] STAT_SAT       = 2'd3;

    // operand sources
    localparam logic [4:0] SRC_ZERO = 5'd0;
    localparam logic [4:0] SRC_IMM  = 5'd1;
    localparam logic [4:0] SRC_Q0   = 5'd2;
    localparam logic [4:0] SRC_V0   = 5'd3;
    localparam logic [4:0] SRC_A0   = 5'd4;
    localparam logic [4:0] SRC_D    = 5'd5;
    localparam logic [4:0] SRC_T    = 5'd6;
    localparam logic [4:0] SRC_INV  = 5'd7;
    localparam logic [4:0] SRC_NEXT = 5'd8;
    localparam logic [4:0] SRC_S    = 5'd9;
    localparam logic [4:0] SRC_H    = 5'd10;
    localparam logic [4:0] SRC_U    = 5'd11;
    localparam logic [4:0] SRC_VV   = 5'd12;
    localparam logic [4:0] SRC_HH   = 5'd13;
    localparam logic [4:0] SRC_C0   = 5'd14;
    localparam logic [4:0] SRC_C1   = 5'd15;
    localparam logic [4:0] SRC_C2   = 5'd16;
    localparam logic [4:0] SRC_C3   = 5'd17;
    localparam logic [4:0] SRC_C4   = 5'd18;
    localparam logic [4:0] SRC_C5   = 5'd19;

    // write-back destinations
    localparam logic [3:0] DST_H   = 4'd0;
    localparam logic [3:0] DST_U   = 4'd1;
    localparam logic [3:0] DST_VV  = 4'd2;
    localparam logic [3:0] DST_HH  = 4'd3;
    localparam logic [3:0] DST_S   = 4'd4;
    localparam logic [3:0] DST_C0  = 4'd5;
    localparam logic [3:0] DST_C1  = 4'd6;
    localparam logic [3:0] DST_C2  = 4'd7;
    localparam logic [3:0] DST_C3  = 4'd8;
    localparam logic [3:0] DST_C4  = 4'd9;
    localparam logic [3:0] DST_C5  = 4'd10;
    localparam logic [3:0] DST_POS = 4'd11;
    localparam logic [3:0] DST_VEL = 4'd12;
    localparam logic [3:0] DST_ACC = 4'd13;
    localparam logic [3:0] DST_JRK = 4'd14;

    // product shift selects
    localparam logic [1:0] SH_NONE   = 2'd0;
    localparam logic [1:0] SH_TIME   = 2'd1;
    localparam logic [1:0] SH_SQUARE = 2'd2;

    localparam int PC_W = 6;
    localparam logic [PC_W-1:0] PC_BUILD = PC_W'(0);
    localparam logic [PC_W-1:0] PC_STEP  = PC_W'(15);

    // one micro-op: dst = sat(k + round((a * b) >> shift))
    typedef struct packed {
        logic [4:0]        a_src;
        logic [4:0]        b_src;
        logic signed [7:0] imm;
        logic [1:0]        shift;
        logic [4:0]        k_src;
        logic [3:0]        dst;
        logic              last;
    } uop_t;

    function automatic uop_t mk_uop(input logic [4:0] a, input logic [4:0] b, input int imm,
                                    input logic [1:0] sh, input logic [4:0] k,
                                    input logic [3:0] d, input logic l);
        uop_t u;
        u.a_src = a;
        u.b_src = b;
        u.imm   = 8'(imm);
        u.shift = sh;
        u.k_src = k;
        u.dst   = d;
        u.last  = l;
        return u;
    endfunction

    // microprogram: coefficient build, then per-tick evaluation
    function automatic uop_t ucode(input logic [PC_W-1:0] pc);
        uop_t u;
        case (pc)
            // V = v*T, H = a*T*T/2
            6'd0:  u = mk_uop(SRC_V0, SRC_T, 0, SH_TIME, SRC_ZERO, DST_VV, 1'b0);
            6'd1:  u = mk_uop(SRC_A0, SRC_T, 0, SH_NONE, SRC_ZERO, DST_U, 1'b0);
            6'd2:  u = mk_uop(SRC_U, SRC_T, 0, SH_SQUARE, SRC_ZERO, DST_HH, 1'b0);
            // c3 = 10D - 6V - 3H
            6'd3:  u = mk_uop(SRC_D, SRC_IMM, 10, SH_NONE, SRC_ZERO, DST_U, 1'b0);
            6'd4:  u = mk_uop(SRC_VV, SRC_IMM, -6, SH_NONE, SRC_U, DST_U, 1'b0);
            6'd5:  u = mk_uop(SRC_HH, SRC_IMM, -3, SH_NONE, SRC_U, DST_C3, 1'b0);
            // c4 = -15D + 8V + 3H
            6'd6:  u = mk_uop(SRC_D, SRC_IMM, -15, SH_NONE, SRC_ZERO, DST_U, 1'b0);
            6'd7:  u = mk_uop(SRC_VV, SRC_IMM, 8, SH_NONE, SRC_U, DST_U, 1'b0);
            6'd8:  u = mk_uop(SRC_HH, SRC_IMM, 3, SH_NONE, SRC_U, DST_C4, 1'b0);
            // c5 = 6D - 3V - H
            6'd9:  u = mk_uop(SRC_D, SRC_IMM, 6, SH_NONE, SRC_ZERO, DST_U, 1'b0);
            6'd10: u = mk_uop(SRC_VV, SRC_IMM, -3, SH_NONE, SRC_U, DST_U, 1'b0);
            6'd11: u = mk_uop(SRC_HH, SRC_IMM, -1, SH_NONE, SRC_U, DST_C5, 1'b0);
            // c0..c2 copies, clipped to 48 bits
            6'd12: u = mk_uop(SRC_Q0, SRC_IMM, 1, SH_NONE, SRC_ZERO, DST_C0, 1'b0);
            6'd13: u = mk_uop(SRC_VV, SRC_IMM, 1, SH_NONE, SRC_ZERO, DST_C1, 1'b0);
            6'd14: u = mk_uop(SRC_HH, SRC_IMM, 1, SH_NONE, SRC_ZERO, DST_C2, 1'b1);
            // normalised time
            6'd15: u = mk_uop(SRC_NEXT, SRC_INV, 0, SH_TIME, SRC_ZERO, DST_S, 1'b0);
            // position
            6'd16: u = mk_uop(SRC_C5, SRC_S, 0, SH_TIME, SRC_C4, DST_H, 1'b0);
            6'd17: u = mk_uop(SRC_H, SRC_S, 0, SH_TIME, SRC_C3, DST_H, 1'b0);
            6'd18: u = mk_uop(SRC_H, SRC_S, 0, SH_TIME, SRC_C2, DST_H, 1'b0);
            6'd19: u = mk_uop(SRC_H, SRC_S, 0, SH_TIME, SRC_C1, DST_H, 1'b0);
            6'd20: u = mk_uop(SRC_H, SRC_S, 0, SH_TIME, SRC_C0, DST_POS, 1'b0);
            // velocity
            6'd21: u = mk_uop(SRC_C4, SRC_IMM, 4, SH_NONE, SRC_ZERO, DST_U, 1'b0);
            6'd22: u = mk_uop(SRC_C5, SRC_IMM, 5, SH_NONE, SRC_ZERO, DST_H, 1'b0);
            6'd23: u = mk_uop(SRC_H, SRC_S, 0, SH_TIME, SRC_U, DST_H, 1'b0);
            6'd24: u = mk_uop(SRC_C3, SRC_IMM, 3, SH_NONE, SRC_ZERO, DST_U, 1'b0);
            6'd25: u = mk_uop(SRC_H, SRC_S, 0, SH_TIME, SRC_U, DST_H, 1'b0);
            6'd26: u = mk_uop(SRC_C2, SRC_IMM, 2, SH_NONE, SRC_ZERO, DST_U, 1'b0);
            6'd27: u = mk_uop(SRC_H, SRC_S, 0, SH_TIME, SRC_U, DST_H, 1'b0);
            6'd28: u = mk_uop(SRC_H, SRC_S, 0, SH_TIME, SRC_C1, DST_H, 1'b0);
            6'd29: u = mk_uop(SRC_H, SRC_INV, 0, SH_TIME, SRC_ZERO, DST_VEL, 1'b0);
            // acceleration
            6'd30: u = mk_uop(SRC_C4, SRC_IMM, 12, SH_NONE, SRC_ZERO, DST_U, 1'b0);
            6'd31: u = mk_uop(SRC_C5, SRC_IMM, 20, SH_NONE, SRC_ZERO, DST_H, 1'b0);
            6'd32: u = mk_uop(SRC_H, SRC_S, 0, SH_TIME, SRC_U, DST_H, 1'b0);
            6'd33: u = mk_uop(SRC_C3, SRC_IMM, 6, SH_NONE, SRC_ZERO, DST_U, 1'b0);
            6'd34: u = mk_uop(SRC_H, SRC_S, 0, SH_TIME, SRC_U, DST_H, 1'b0);
            6'd35: u = mk_uop(SRC_C2, SRC_IMM, 2, SH_NONE, SRC_ZERO, DST_U, 1'b0);
            6'd36: u = mk_uop(SRC_H, SRC_S, 0, SH_TIME, SRC_U, DST_H, 1'b0);
            6'd37: u = mk_uop(SRC_H, SRC_INV, 0, SH_TIME, SRC_ZERO, DST_H, 1'b0);
            6'd38: u = mk_uop(SRC_H, SRC_INV, 0, SH_TIME, SRC_ZERO, DST_ACC, 1'b0);
            // jerk
            6'd39: u = mk_uop(SRC_C4, SRC_IMM, 24, SH_NONE, SRC_ZERO, DST_U, 1'b0);
            6'd40: u = mk_uop(SRC_C5, SRC_IMM, 60, SH_NONE, SRC_ZERO, DST_H, 1'b0);
            6'd41: u = mk_uop(SRC_H, SRC_S, 0, SH_TIME, SRC_U, DST_H, 1'b0);
            6'd42: u = mk_uop(SRC_C3, SRC_IMM, 6, SH_NONE, SRC_ZERO, DST_U, 1'b0);
            6'd43: u = mk_uop(SRC_H, SRC_S, 0, SH_TIME, SRC_U, DST_H, 1'b0);
            6'd44: u = mk_uop(SRC_H, SRC_INV, 0, SH_TIME, SRC_ZERO, DST_H, 1'b0);
            6'd45: u = mk_uop(SRC_H, SRC_INV, 0, SH_TIME, SRC_ZERO, DST_H, 1'b0);
            6'd46: u = mk_uop(SRC_H, SRC_INV, 0, SH_TIME, SRC_ZERO, DST_JRK, 1'b1);
            default: u = mk_uop(SRC_ZERO, SRC_ZERO, 0, SH_NONE, SRC_ZERO, DST_H, 1'b1);
        endcase
        return u;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/quintic_trajectory_generator_top.sv =====
// Quintic trajectory generator: microcoded sequencer around one shared multiply-add unit.
//
// Configuration: cfg_wen writes cfg_data into register cfg_index (0 start position,
// 1 start velocity, 2 start acceleration, 3 target, 4 duration, 5 inverse duration).
// Writes mark coefficients stale, clear elapsed time; user writes while idle, not enforced.
// Input channel: one beat of time_step per servo tick (in_valid / in_stall).
// Output channel: one beat per tick with position, velocity, acceleration, jerk, moving
// and status (out_valid / out_stall).
// Sequence: for a zero step, a zero duration or the end of the move the decision step goes
// straight to the done state. A tick on the curve runs 32 micro-ops (fetch, four 32x32 partial
// products, round, write-back) through the one multiplier; after a configuration write the
// first such tick also rebuilds the six coefficients, 15 more micro-ops.
// Throughput: one tick at a time; in_stall is high from acceptance until the result has
// been moved to the output register.
// A finished result waits in the output register while out_stall is high; the next tick
// is taken meanwhile, but its result waits until the previous beat has gone.
// Reset clears all configuration registers, coefficients and elapsed time to zero.
`default_nettype none
module quintic_trajectory_generator_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wen,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [47:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [31:0]        time_step,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      position,
    output logic signed [31:0]      velocity,
    output logic signed [31:0]      acceleration,
    output logic signed [47:0]      jerk,
    output logic                    moving,
    output logic [1:0]              status
);
    import qtg_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_FETCH  = 3'd2;
    localparam logic [2:0] S_MUL    = 3'd3;
    localparam logic [2:0] S_ROUND  = 3'd4;
    localparam logic [2:0] S_WB     = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    // configuration and trajectory state
    logic [31:0]        start_pos_reg, start_pos_next;
    logic [31:0]        start_vel_reg, start_vel_next;
    logic [31:0]        start_acc_reg, start_acc_next;
    logic [31:0]        target_reg, target_next;
    logic [31:0]        dur_reg, dur_next;
    logic [47:0]        inv_reg, inv_next;
    logic [31:0]        elapsed_reg, elapsed_next;
    logic               dirty_reg, dirty_next;
    logic               clipped_reg, clipped_next;
    logic [47:0]        c0_reg, c0_next, c1_reg, c1_next, c2_reg, c2_next;
    logic [47:0]        c3_reg, c3_next, c4_reg, c4_next, c5_reg, c5_next;

    // sequencer and working registers
    logic [2:0]         state_reg, state_next;
    logic [PC_W-1:0]    pc_reg, pc_next;
    logic [1:0]         mcnt_reg, mcnt_next;
    logic [31:0]        dt_reg, dt_next;
    logic [32:0]        tnext_reg, tnext_next;
    logic [S_W-1:0]     s_reg, s_next;
    logic [63:0]        h_reg, h_next, u_reg, u_next, vv_reg, vv_next, hh_reg, hh_next;
    logic [63:0]        mag_a_reg, mag_a_next, mag_b_reg, mag_b_next;
    logic               neg_reg, neg_next;
    logic [127:0]       prod_reg, prod_next;
    logic [63:0]        rmag_reg, rmag_next;
    logic               sat_reg, sat_next;

    // result staging and output register
    logic [31:0]        rpos_reg, rpos_next, rvel_reg, rvel_next, racc_reg, racc_next;
    logic [47:0]        rjrk_reg, rjrk_next;
    logic               rmov_reg, rmov_next;
    logic [1:0]         rstat_reg, rstat_next;
    logic               out_valid_reg, out_valid_next;
    logic [31:0]        opos_reg, opos_next, ovel_reg, ovel_next, oacc_reg, oacc_next;
    logic [47:0]        ojrk_reg, ojrk_next;
    logic               omov_reg, omov_next;
    logic [1:0]         ostat_reg, ostat_next;

    uop_t               uop;
    logic [63:0]        a_val, b_val, k_val, d_val;
    logic [31:0]        a_half, b_half;
    logic [63:0]        pp;
    logic [127:0]       pp_sh, shifted;
    logic               mul_ovf;
    logic [63:0]        addend, sum_sat;
    logic [64:0]        sum;
    logic               add_ovf, cl32_ovf, cl48_ovf;
    logic [31:0]        val32;
    logic [47:0]        val48;
    logic [S_W-1:0]     val_s;
    logic               sat_wb;
    logic [32:0]        t_sum;
    logic               accept_in, load_out;

    assign uop = ucode(pc_reg);
    assign d_val = {{32{target_reg[31]}}, target_reg} - {{32{start_pos_reg[31]}}, start_pos_reg};

    // operand select over the named registers
    function automatic logic [63:0] pick(input logic [4:0] code);
        logic [63:0] v;
        case (code)
            SRC_ZERO: v = '0;
            SRC_IMM:  v = {{56{uop.imm[7]}}, uop.imm};
            SRC_Q0:   v = {{32{start_pos_reg[31]}}, start_pos_reg};
            SRC_V0:   v = {{32{start_vel_reg[31]}}, start_vel_reg};
            SRC_A0:   v = {{32{start_acc_reg[31]}}, start_acc_reg};
            SRC_D:    v = d_val;
            SRC_T:    v = {32'd0, dur_reg};
            SRC_INV:  v = {16'd0, inv_reg};
            SRC_NEXT: v = {31'd0, tnext_reg};
            SRC_S:    v = 64'(s_reg);
            SRC_H:    v = h_reg;
            SRC_U:    v = u_reg;
            SRC_VV:   v = vv_reg;
            SRC_HH:   v = hh_reg;
            SRC_C0:   v = {{16{c0_reg[47]}}, c0_reg};
            SRC_C1:   v = {{16{c1_reg[47]}}, c1_reg};
            SRC_C2:   v = {{16{c2_reg[47]}}, c2_reg};
            SRC_C3:   v = {{16{c3_reg[47]}}, c3_reg};
            SRC_C4:   v = {{16{c4_reg[47]}}, c4_reg};
            SRC_C5:   v = {{16{c5_reg[47]}}, c5_reg};
            default:  v = '0;
        endcase
        return v;
    endfunction

    // operands for the current micro-op
    always_comb
    begin
        a_val = pick(uop.a_src);
        b_val = pick(uop.b_src);
        k_val = pick(uop.k_src);
    end

    // one 32x32 partial product per cycle
    assign a_half = mcnt_reg[0] ? mag_a_reg[63:32] : mag_a_reg[31:0];
    assign b_half = mcnt_reg[1] ? mag_b_reg[63:32] : mag_b_reg[31:0];
    assign pp     = {32'd0, a_half} * {32'd0, b_half};

    always_comb
    begin
        case (mcnt_reg)
            2'd0:    pp_sh = {64'd0, pp};
            2'd1:    pp_sh = {32'd0, pp, 32'd0};
            2'd2:    pp_sh = {32'd0, pp, 32'd0};
            2'd3:    pp_sh = {pp, 64'd0};
            default: pp_sh = {64'd0, pp};
        endcase
    end

    // round to nearest, ties away from zero, on the magnitude
    always_comb
    begin
        case (uop.shift)
            SH_NONE:   shifted = prod_reg;
            SH_TIME:   shifted = (prod_reg + (128'd1 << (TIME_FRAC - 1))) >> TIME_FRAC;
            SH_SQUARE: shifted = (prod_reg + (128'd1 << (SH_WIDE - 1))) >> SH_WIDE;
            default:   shifted = prod_reg;
        endcase
    end
    assign mul_ovf = |shifted[127:63];

    // signed accumulate with saturation: k + (+/-)magnitude
    assign addend  = neg_reg ? ~rmag_reg : rmag_reg;
    assign sum     = {k_val[63], k_val} + {addend[63], addend} + {64'd0, neg_reg};
    assign add_ovf = sum[64] != sum[63];
    assign sum_sat = add_ovf ? (sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : sum[63:0];

    // width clamps for the destinations
    assign cl32_ovf = !((&sum_sat[63:31]) || !(|sum_sat[63:31]));
    assign cl48_ovf = !((&sum_sat[63:47]) || !(|sum_sat[63:47]));
    assign val32 = cl32_ovf ? (sum_sat[63] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}})
                            : sum_sat[31:0];
    assign val48 = cl48_ovf ? (sum_sat[63] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}})
                            : sum_sat[47:0];
    assign val_s = (sum_sat > 64'(S_ONE)) ? S_ONE : sum_sat[S_W-1:0];

    always_comb
    begin
        sat_wb = sat_reg | add_ovf;
        case (uop.dst)
            DST_C0, DST_C1, DST_C2, DST_C3, DST_C4, DST_C5, DST_JRK: sat_wb = sat_reg | add_ovf | cl48_ovf;
            DST_POS, DST_VEL, DST_ACC: sat_wb = sat_reg | add_ovf | cl32_ovf;
            default: sat_wb = sat_reg | add_ovf;
        endcase
    end

    assign t_sum     = {1'b0, elapsed_reg} + {1'b0, dt_reg};
    assign accept_in = in_valid && !in_stall;
    assign load_out  = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    // sequencer and datapath next state
    always_comb
    begin
        start_pos_next = start_pos_reg;
        start_vel_next = start_vel_reg;
        start_acc_next = start_acc_reg;
        target_next    = target_reg;
        dur_next       = dur_reg;
        inv_next       = inv_reg;
        elapsed_next   = elapsed_reg;
        dirty_next     = dirty_reg;
        clipped_next   = clipped_reg;
        c0_next = c0_reg; c1_next = c1_reg; c2_next = c2_reg;
        c3_next = c3_reg; c4_next = c4_reg; c5_next = c5_reg;
        state_next = state_reg;
        pc_next    = pc_reg;
        mcnt_next  = mcnt_reg;
        dt_next    = dt_reg;
        tnext_next = tnext_reg;
        s_next     = s_reg;
        h_next = h_reg; u_next = u_reg; vv_next = vv_reg; hh_next = hh_reg;
        mag_a_next = mag_a_reg;
        mag_b_next = mag_b_reg;
        neg_next   = neg_reg;
        prod_next  = prod_reg;
        rmag_next  = rmag_reg;
        sat_next   = sat_reg;
        rpos_next = rpos_reg; rvel_next = rvel_reg; racc_next = racc_reg;
        rjrk_next = rjrk_reg; rmov_next = rmov_reg; rstat_next = rstat_reg;
        out_valid_next = out_valid_reg && out_stall;
        opos_next = opos_reg; ovel_next = ovel_reg; oacc_next = oacc_reg;
        ojrk_next = ojrk_reg; omov_next = omov_reg; ostat_next = ostat_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept_in)
                begin
                    dt_next    = time_step;
                    state_next = S_DECIDE;
                end
            end
            // special cases, time advance and choice of program entry
            S_DECIDE:
            begin
                rpos_next  = '0;
                rvel_next  = '0;
                racc_next  = '0;
                rjrk_next  = '0;
                rstat_next = STAT_OK;
                state_next = S_DONE;
                if (dt_reg == 32'd0)
                begin
                    rstat_next = STAT_ZERO_STEP;
                    rmov_next  = elapsed_reg < dur_reg;
                end
                else if (dur_reg == 32'd0 && (start_vel_reg != 32'd0 || start_acc_reg != 32'd0))
                begin
                    rstat_next = STAT_ZERO_DUR;
                    rmov_next  = elapsed_reg < dur_reg;
                end
                else if (dur_reg == 32'd0)
                begin
                    rpos_next    = start_pos_reg;
                    rmov_next    = 1'b0;
                    elapsed_next = '0;
                end
                else if (t_sum >= {1'b0, dur_reg})
                begin
                    rpos_next    = target_reg;
                    rmov_next    = 1'b0;
                    elapsed_next = dur_reg;
                end
                else
                begin
                    elapsed_next = t_sum[31:0];
                    tnext_next   = t_sum;
                    rmov_next    = 1'b1;
                    state_next   = S_FETCH;
                    if (dirty_reg)
                    begin
                        pc_next  = PC_BUILD;
                        sat_next = 1'b0;
                    end
                    else
                    begin
                        pc_next  = PC_STEP;
                        sat_next = clipped_reg;
                    end
                end
            end
            // operand magnitudes and product sign
            S_FETCH:
            begin
                mag_a_next = a_val[63] ? (64'd0 - a_val) : a_val;
                mag_b_next = b_val[63] ? (64'd0 - b_val) : b_val;
                neg_next   = a_val[63] ^ b_val[63];
                prod_next  = '0;
                mcnt_next  = 2'd0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                prod_next = prod_reg + pp_sh;
                mcnt_next = mcnt_reg + 2'd1;
                if (mcnt_reg == 2'd3)
                begin
                    state_next = S_ROUND;
                end
            end
            S_ROUND:
            begin
                rmag_next  = mul_ovf ? {1'b0, {63{1'b1}}} : shifted[63:0];
                sat_next   = sat_reg | mul_ovf;
                state_next = S_WB;
            end
            S_WB:
            begin
                sat_next = sat_wb;
                case (uop.dst)
                    DST_H:   h_next   = sum_sat;
                    DST_U:   u_next   = sum_sat;
                    DST_VV:  vv_next  = sum_sat;
                    DST_HH:  hh_next  = sum_sat;
                    DST_S:   s_next   = val_s;
                    DST_C0:  c0_next  = val48;
                    DST_C1:  c1_next  = val48;
                    DST_C2:  c2_next  = val48;
                    DST_C3:  c3_next  = val48;
                    DST_C4:  c4_next  = val48;
                    DST_C5:  c5_next  = val48;
                    DST_POS: rpos_next = val32;
                    DST_VEL: rvel_next = val32;
                    DST_ACC: racc_next = val32;
                    DST_JRK: rjrk_next = val48;
                    default: h_next   = h_reg;
                endcase
                if (!uop.last)
                begin
                    pc_next    = pc_reg + PC_W'(1);
                    state_next = S_FETCH;
                end
                else if (pc_reg < PC_STEP)
                begin
                    // coefficients rebuilt: carry on with the evaluation
                    clipped_next = sat_wb;
                    dirty_next   = 1'b0;
                    pc_next      = PC_STEP;
                    state_next   = S_FETCH;
                end
                else
                begin
                    rstat_next = sat_wb ? STAT_SAT : STAT_OK;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // result into the output register
        if (load_out)
        begin
            out_valid_next = 1'b1;
            opos_next  = rpos_reg;
            ovel_next  = rvel_reg;
            oacc_next  = racc_reg;
            ojrk_next  = rjrk_reg;
            omov_next  = rmov_reg;
            ostat_next = rstat_reg;
        end

        // configuration writes
        if (cfg_wen)
        begin
            case (cfg_index)
                REG_START_POS: start_pos_next = cfg_data[31:0];
                REG_START_VEL: start_vel_next = cfg_data[31:0];
                REG_START_ACC: start_acc_next = cfg_data[31:0];
                REG_TARGET:    target_next    = cfg_data[31:0];
                REG_DURATION:  dur_next       = cfg_data[31:0];
                REG_INV_DUR:   inv_next       = cfg_data;
                default:       inv_next       = inv_reg;
            endcase
            if (cfg_index <= REG_INV_DUR)
            begin
                dirty_next   = 1'b1;
                elapsed_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_pos_reg <= '0;
            start_vel_reg <= '0;
            start_acc_reg <= '0;
            target_reg    <= '0;
            dur_reg       <= '0;
            inv_reg       <= '0;
            elapsed_reg   <= '0;
            dirty_reg     <= 1'b0;
            clipped_reg   <= 1'b0;
            c0_reg <= '0; c1_reg <= '0; c2_reg <= '0;
            c3_reg <= '0; c4_reg <= '0; c5_reg <= '0;
            state_reg     <= S_IDLE;
            pc_reg        <= '0;
            mcnt_reg      <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            start_pos_reg <= start_pos_next;
            start_vel_reg <= start_vel_next;
            start_acc_reg <= start_acc_next;
            target_reg    <= target_next;
            dur_reg       <= dur_next;
            inv_reg       <= inv_next;
            elapsed_reg   <= elapsed_next;
            dirty_reg     <= dirty_next;
            clipped_reg   <= clipped_next;
            c0_reg <= c0_next; c1_reg <= c1_next; c2_reg <= c2_next;
            c3_reg <= c3_next; c4_reg <= c4_next; c5_reg <= c5_next;
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            mcnt_reg      <= mcnt_next;
            sat_reg       <= sat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        dt_reg    <= dt_next;
        tnext_reg <= tnext_next;
        s_reg     <= s_next;
        h_reg     <= h_next;
        u_reg     <= u_next;
        vv_reg    <= vv_next;
        hh_reg    <= hh_next;
        mag_a_reg <= mag_a_next;
        mag_b_reg <= mag_b_next;
        neg_reg   <= neg_next;
        prod_reg  <= prod_next;
        rmag_reg  <= rmag_next;
        rpos_reg  <= rpos_next;
        rvel_reg  <= rvel_next;
        racc_reg  <= racc_next;
        rjrk_reg  <= rjrk_next;
        rmov_reg  <= rmov_next;
        rstat_reg <= rstat_next;
        opos_reg  <= opos_next;
        ovel_reg  <= ovel_next;
        oacc_reg  <= oacc_next;
        ojrk_reg  <= ojrk_next;
        omov_reg  <= omov_next;
        ostat_reg <= ostat_next;
    end

    assign in_stall     = state_reg != S_IDLE;
    assign out_valid    = out_valid_reg;
    assign position     = opos_reg;
    assign velocity     = ovel_reg;
    assign acceleration = oacc_reg;
    assign jerk         = ojrk_reg;
    assign moving       = omov_reg;
    assign status       = ostat_reg;

    // an accepted beat always goes to the decision step first
    assert property (@(posedge clk) disable iff (!rst_n)
        accept_in |=> state_reg == S_DECIDE)
        else $error("accepted tick did not reach decision step");

    // the multiplier moves on to rounding after the last partial product
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL && mcnt_reg == 2'd3) |=> state_reg == S_ROUND)
        else $error("partial product sequence overran");

    // finishing the coefficient build clears the stale flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WB && uop.last && pc_reg < PC_STEP) |=> (!dirty_reg && pc_reg == PC_STEP))
        else $error("coefficient rebuild did not complete");

endmodule
`default_nettype wire
